/* hw/rtl/dc2d_pkg.sv */
package dc2d_pkg;

  typedef enum logic [1:0] {
    OP_WR_SAMPLE = 2'd0,
    OP_WR_WEIGHT = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_IN_HEIGHT     = 3'd0,
    REG_IN_WIDTH      = 3'd1,
    REG_IN_CHANNELS   = 3'd2,
    REG_FILTER_HEIGHT = 3'd3,
    REG_FILTER_WIDTH  = 3'd4,
    REG_STRIDES       = 3'd5,
    REG_PADDINGS      = 3'd6,
    REG_DILATIONS     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN,
    ST_SAT,
    ST_DONE
  } state_t;

  localparam int SumW = 64;

endpackage

/* hw/rtl/dc2d_ram.sv */
module dc2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dc2d_mac.sv */
// Multiply-accumulate datapath: registered product, then add into a wide sum.
module dc2d_mac (
  input  logic               clk,
  input  logic               clear,
  input  logic signed [47:0] init,
  input  logic               en,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [63:0] sum
);

  logic signed [31:0] prod_r;
  logic               pv_r;
  logic signed [63:0] sum_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    pv_r   <= en && !clear;
    if (clear) begin
      sum_r <= 64'(init);
    end else if (pv_r) begin
      sum_r <= sum_r + 64'(prod_r);
    end
  end

  assign sum = sum_r;

endmodule

/* hw/rtl/direct_conv2d_engine.sv */
// Direct 2D convolution engine for one image. Opcode 0 stores an input sample, opcode 1 a
// filter weight (written in the accept cycle, no result); out-of-buffer writes are
// dropped. Opcode 2 computes one output element: it walks input channels x filter rows x
// filter columns, one tap per cycle through the single read port of each buffer,
// multiplies the Q1.15 operands and sums them onto accum_in, saturating to 48 bits once
// at the end. Every tap of the C channels and R x S filter is stepped over, also taps
// outside the image, and the next transaction can be taken in the same cycle that the
// result is presented. Output coordinates beyond the output size return status 1 with a
// zero value. Both buffers hold garbage until written; never compute over unwritten entries.
// One transaction is worked on at a time; a finished result sits in the output register
// until taken while the next input transaction is already accepted.
module direct_conv2d_engine #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_IMAGE_SIZE   = 32,
  parameter int MAX_FILTER_SIZE  = 8,
  parameter int MAX_OUT_CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_out_channel,
  input  logic [3:0]         in_in_channel,
  input  logic [4:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [15:0] in_value,
  input  logic signed [47:0] in_accum_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_res_channel,
  output logic [4:0]         out_res_row,
  output logic [4:0]         out_res_col,
  output logic signed [47:0] out_result_value,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import dc2d_pkg::*;

  localparam int ImgW  = $clog2(MAX_IMAGE_SIZE);
  localparam int IcW   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int FltW  = (MAX_FILTER_SIZE > 1) ? $clog2(MAX_FILTER_SIZE) : 1;
  localparam int OcW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int SDep  = MAX_IN_CHANNELS * MAX_IMAGE_SIZE * MAX_IMAGE_SIZE;
  localparam int WDep  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_FILTER_SIZE * MAX_FILTER_SIZE;
  localparam int SAw   = $clog2(SDep);
  localparam int WAw   = $clog2(WDep);
  localparam int CntW  = 9;   // channel and tap counters (up to 511)
  localparam int CoordW = 16; // signed coordinate math

  // ---------------- configuration registers ----------------
  logic [5:0] h_r, w_r;
  logic [4:0] c_r;
  logic [3:0] fh_r, fw_r;
  logic [7:0] str_r, pad_r, dil_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= 6'd32; w_r <= 6'd32; c_r <= 5'd1; fh_r <= 4'd3; fw_r <= 4'd3;
      str_r <= 8'h11; pad_r <= 8'h00; dil_r <= 8'h11;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IN_HEIGHT:     h_r   <= cfg_data[5:0];
        REG_IN_WIDTH:      w_r   <= cfg_data[5:0];
        REG_IN_CHANNELS:   c_r   <= cfg_data[4:0];
        REG_FILTER_HEIGHT: fh_r  <= cfg_data[3:0];
        REG_FILTER_WIDTH:  fw_r  <= cfg_data[3:0];
        REG_STRIDES:       str_r <= cfg_data;
        REG_PADDINGS:      pad_r <= cfg_data;
        REG_DILATIONS:     dil_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective (clamped) geometry.
  function automatic logic [CntW-1:0] clampv(input logic [7:0] v, input int hi);
    logic [CntW-1:0] r;
    begin
      if (v == 8'd0) r = CntW'(1);
      else if (int'(v) > hi) r = CntW'(hi);
      else r = CntW'(v);
      return r;
    end
  endfunction

  function automatic logic [3:0] nz(input logic [3:0] v);
    begin
      return (v == 4'd0) ? 4'd1 : v;
    end
  endfunction

  logic [CntW-1:0] eh, ew, ec, er, es;
  logic [3:0] vs, hs, vd, hd, vp, hp;
  assign eh = clampv({2'b0, h_r}, MAX_IMAGE_SIZE);
  assign ew = clampv({2'b0, w_r}, MAX_IMAGE_SIZE);
  assign ec = clampv({3'b0, c_r}, MAX_IN_CHANNELS);
  assign er = clampv({4'b0, fh_r}, MAX_FILTER_SIZE);
  assign es = clampv({4'b0, fw_r}, MAX_FILTER_SIZE);
  assign vs = nz(str_r[7:4]);  assign hs = nz(str_r[3:0]);
  assign vd = nz(dil_r[7:4]);  assign hd = nz(dil_r[3:0]);
  assign vp = pad_r[7:4];      assign hp = pad_r[3:0];

  // ---------------- transaction capture ----------------
  state_t state_r, state_nxt;
  logic [3:0] oc_r;
  logic [4:0] row_r, col_r;
  logic signed [47:0] acc_in_r;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Write path: buffer writes are done in the accept cycle.
  logic s_we, w_we;
  logic [SAw-1:0] s_waddr;
  logic [WAw-1:0] w_waddr;
  always_comb begin
    s_we = in_acc && (opcode_t'(in_opcode) == OP_WR_SAMPLE)
           && (int'(in_in_channel) < MAX_IN_CHANNELS)
           && (int'(in_row) < MAX_IMAGE_SIZE) && (int'(in_col) < MAX_IMAGE_SIZE);
    w_we = in_acc && (opcode_t'(in_opcode) == OP_WR_WEIGHT)
           && (int'(in_out_channel) < MAX_OUT_CHANNELS)
           && (int'(in_in_channel) < MAX_IN_CHANNELS)
           && (int'(in_row) < MAX_FILTER_SIZE) && (int'(in_col) < MAX_FILTER_SIZE);
    s_waddr = SAw'((32'(in_in_channel) * MAX_IMAGE_SIZE + 32'(in_row)) * MAX_IMAGE_SIZE
                   + 32'(in_col));
    w_waddr = WAw'(((32'(in_out_channel) * MAX_IN_CHANNELS + 32'(in_in_channel))
                    * MAX_FILTER_SIZE + 32'(in_row)) * MAX_FILTER_SIZE + 32'(in_col));
  end

  // ---------------- output range check ----------------
  logic signed [CoordW-1:0] numh, numw;
  always_comb begin
    numh = CoordW'(CoordW'(eh) + CoordW'(2 * vp) - CoordW'(vd) * (CoordW'(er) - 1) - 1);
    numw = CoordW'(CoordW'(ew) + CoordW'(2 * hp) - CoordW'(hd) * (CoordW'(es) - 1) - 1);
  end

  // Division by a small stride: size_out > row iff row*stride <= num, no divider needed.
  logic out_bad;
  always_comb begin
    out_bad = (int'(oc_r) >= MAX_OUT_CHANNELS)
           || (numh < 0) || (numw < 0)
           || (CoordW'(row_r) * CoordW'(vs) > numh)
           || (CoordW'(col_r) * CoordW'(hs) > numw);
  end

  // ---------------- tap walk ----------------
  logic [CntW-1:0] kc_r, kr_r, ks_r;
  logic signed [CoordW-1:0] ybase_r, xbase_r;
  logic signed [CoordW-1:0] y, x;
  logic tap_ok, last_tap;
  logic bad_r;
  always_comb begin
    y = ybase_r + CoordW'(vd) * CoordW'(kr_r);
    x = xbase_r + CoordW'(hd) * CoordW'(ks_r);
    tap_ok = (y >= 0) && (y < CoordW'(eh)) && (x >= 0) && (x < CoordW'(ew));
    last_tap = (ks_r == es - 1) && (kr_r == er - 1) && (kc_r == ec - 1);
  end

  logic [SAw-1:0] s_raddr;
  logic [WAw-1:0] w_raddr;
  always_comb begin
    s_raddr = SAw'((32'(kc_r[IcW-1:0]) * MAX_IMAGE_SIZE + 32'(y[ImgW-1:0]))
                   * MAX_IMAGE_SIZE + 32'(x[ImgW-1:0]));
    w_raddr = WAw'(((32'(oc_r[OcW-1:0]) * MAX_IN_CHANNELS + 32'(kc_r[IcW-1:0]))
                    * MAX_FILTER_SIZE + 32'(kr_r[FltW-1:0])) * MAX_FILTER_SIZE
                   + 32'(ks_r[FltW-1:0]));
  end

  logic signed [15:0] s_rd, w_rd;
  dc2d_ram #(.Width(16), .Depth(SDep)) u_sample (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(in_value), .raddr(s_raddr), .rdata(s_rd)
  );
  dc2d_ram #(.Width(16), .Depth(WDep)) u_weight (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_value), .raddr(w_raddr), .rdata(w_rd)
  );

  // Read-valid is registered alongside the registered RAM read data.
  logic rd_v_r;
  logic issue;
  logic [1:0] drain_r;
  assign issue = (state_r == ST_ISSUE);

  logic mac_clear;
  logic signed [63:0] sum;
  dc2d_mac u_mac (
    .clk, .clear(mac_clear), .init(acc_in_r), .en(rd_v_r),
    .a(s_rd), .b(w_rd), .sum(sum)
  );

  // ---------------- output register ----------------
  logic ov_r, st_r;
  logic signed [47:0] val_r;
  logic [3:0] roc_r;
  logic [4:0] rrow_r, rcol_r;
  logic res_load;

  assign out_valid        = ov_r;
  assign out_res_channel  = roc_r;
  assign out_res_row      = rrow_r;
  assign out_res_col      = rcol_r;
  assign out_result_value = val_r;
  assign out_status       = st_r;

  // Load the output register once the finished element finds it free or draining.
  assign res_load = (state_r == ST_SAT || state_r == ST_DONE) && (!ov_r || out_ready);

  // Accept a new transaction when idle; the output register frees the engine.
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    mac_clear = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_acc && opcode_t'(in_opcode) == OP_COMPUTE) state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        mac_clear = 1'b1;
        state_nxt = bad_r ? ST_DONE : ST_ISSUE;
      end
      ST_ISSUE: if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 2'd2) state_nxt = ST_SAT;
      ST_SAT:   if (!ov_r || out_ready) state_nxt = ST_IDLE;
      ST_DONE:  if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
      drain_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rd_v_r <= issue && tap_ok;
      drain_r <= (state_r == ST_DRAIN) ? drain_r + 2'd1 : 2'd0;
      if (res_load) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      oc_r     <= in_out_channel;
      row_r    <= in_row;
      col_r    <= in_col;
      acc_in_r <= in_accum_in;
    end
    if (state_r == ST_SIZE) begin
      bad_r   <= out_bad;
      ybase_r <= CoordW'(row_r) * CoordW'(vs) - CoordW'(vp);
      xbase_r <= CoordW'(col_r) * CoordW'(hs) - CoordW'(hp);
    end
    if (state_r == ST_CHECK) begin
      kc_r <= '0; kr_r <= '0; ks_r <= '0;
    end else if (issue) begin
      if (ks_r == es - 1) begin
        ks_r <= '0;
        if (kr_r == er - 1) begin
          kr_r <= '0;
          kc_r <= kc_r + 1'b1;
        end else begin
          kr_r <= kr_r + 1'b1;
        end
      end else begin
        ks_r <= ks_r + 1'b1;
      end
    end
    if (res_load) begin
      roc_r  <= oc_r;
      rrow_r <= row_r;
      rcol_r <= col_r;
      st_r   <= (state_r == ST_DONE);
      if (state_r == ST_DONE) val_r <= '0;
      else if (sum > 64'sh7FFF_FFFF_FFFF) val_r <= 48'sh7FFF_FFFF_FFFF;
      else if (sum < -64'sh8000_0000_0000) val_r <= 48'sh8000_0000_0000;
      else val_r <= sum[47:0];
    end
  end

endmodule

/* hw/rtl/dc2d_checker.sv */
module dc2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_result_value,
  input logic        out_status
);
  import dc2d_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result dropped while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_value == 48'd0)
    else $error("out of range result not zero");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_COMPUTE |=> !in_ready)
    else $error("engine accepted during compute");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind direct_conv2d_engine dc2d_checker u_dc2d_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .out_valid, .out_ready,
  .out_result_value, .out_status
);

/* tb/direct_conv2d_engine_tb.sv */
module direct_conv2d_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dc2d_pkg::*;

  localparam int IMG = 32;
  localparam int ICH = 16;
  localparam int FLT = 8;
  localparam int DRAIN_CYCLES = 1100;

  typedef struct {
    opcode_t            op;
    bit [3:0]           oc;
    bit [3:0]           ic;
    bit [4:0]           row;
    bit [4:0]           col;
    logic signed [15:0] val;
    logic signed [47:0] acc;
  } conv_req_t;

  typedef struct {
    bit [3:0]           ch;
    bit [4:0]           row;
    bit [4:0]           col;
    logic signed [47:0] val;
    bit                 status;
  } conv_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [3:0]         in_out_channel;
  logic [3:0]         in_in_channel;
  logic [4:0]         in_row;
  logic [4:0]         in_col;
  logic signed [15:0] in_value;
  logic signed [47:0] in_accum_in;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_res_channel;
  logic [4:0]         out_res_row;
  logic [4:0]         out_res_col;
  logic signed [47:0] out_result_value;
  logic               out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [7:0]         cfg_data;

  direct_conv2d_engine dut (.*);

  // Pending requests for the driver, element sums expected back from the engine.
  conv_req_t req_q[$];
  conv_res_t sum_q[$];

  // Shadow copy of the buffers, with a written flag per entry.
  shortint sample_mem[ICH*IMG*IMG];
  shortint weight_mem[ICH*ICH*FLT*FLT];
  bit      sample_set[ICH*IMG*IMG];
  bit      weight_set[ICH*ICH*FLT*FLT];

  // Shadow register file, already masked to the register widths.
  bit [5:0] r_height, r_width;
  bit [4:0] r_chans;
  bit [3:0] r_fh, r_fw;
  bit [7:0] r_strides, r_pads, r_dils;

  int  snd_idle, rcv_idle;
  bit  hold_send;
  bit  sent_done;
  bit  failed;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int nz(bit [3:0] n);
    return n == 0 ? 1 : int'(n);
  endfunction

  function automatic int axis_len(int size, int pad, int dil, int taps, int stride);
    int num;
    num = size + 2 * pad - dil * (taps - 1) - 1;
    return num < 0 ? 0 : num / stride + 1;
  endfunction

  // Output grid size under the current register settings.
  task automatic grid_size(output int ho, output int wo);
    ho = axis_len(clampi(r_height, 1, IMG), r_pads[7:4], nz(r_dils[7:4]),
                  clampi(r_fh, 1, FLT), nz(r_strides[7:4]));
    wo = axis_len(clampi(r_width, 1, IMG), r_pads[3:0], nz(r_dils[3:0]),
                  clampi(r_fw, 1, FLT), nz(r_strides[3:0]));
  endtask

  // Queue a buffer write (or an ignored opcode) and update the shadow buffers.
  task automatic push_write(opcode_t op, bit [3:0] oc, bit [3:0] ic, bit [4:0] row,
                            bit [4:0] col, logic signed [15:0] v);
    conv_req_t it;
    it.op = op; it.oc = oc; it.ic = ic; it.row = row; it.col = col;
    it.val = v; it.acc = 48'({$urandom, $urandom});
    if (op == OP_WR_SAMPLE) begin
      sample_mem[(ic * IMG + row) * IMG + col] = v;
      sample_set[(ic * IMG + row) * IMG + col] = 1'b1;
    end else if (op == OP_WR_WEIGHT && row < FLT && col < FLT) begin
      weight_mem[((oc * ICH + ic) * FLT + row) * FLT + col] = v;
      weight_set[((oc * ICH + ic) * FLT + row) * FLT + col] = 1'b1;
    end
    req_q.push_back(it);
  endtask

  // Queue one compute and its expected sum. Any tap entry not yet loaded gets
  // a random write queued ahead of the compute, so no garbage is ever read.
  task automatic push_compute(bit [3:0] oc, bit [4:0] row, bit [4:0] col,
                              logic signed [47:0] acc);
    int h, w, c, r, s, vs, hs, vd, hd, vp, hp, ho, wo, y, x, si, wi;
    longint sum;
    conv_req_t it;
    conv_res_t e;
    h = clampi(r_height, 1, IMG); w = clampi(r_width, 1, IMG);
    c = clampi(r_chans, 1, ICH);
    r = clampi(r_fh, 1, FLT); s = clampi(r_fw, 1, FLT);
    vs = nz(r_strides[7:4]); hs = nz(r_strides[3:0]);
    vd = nz(r_dils[7:4]); hd = nz(r_dils[3:0]);
    vp = r_pads[7:4]; hp = r_pads[3:0];
    grid_size(ho, wo);
    e.ch = oc; e.row = row; e.col = col; e.val = '0; e.status = 1'b0;
    if (int'(row) >= ho || int'(col) >= wo) begin
      e.status = 1'b1;
    end else begin
      sum = acc;
      for (int kc = 0; kc < c; kc++) begin
        for (int kr = 0; kr < r; kr++) begin
          y = vs * int'(row) + vd * kr - vp;
          if (y < 0 || y >= h) continue;
          for (int ks = 0; ks < s; ks++) begin
            x = hs * int'(col) + hd * ks - hp;
            if (x < 0 || x >= w) continue;
            si = (kc * IMG + y) * IMG + x;
            wi = ((int'(oc) * ICH + kc) * FLT + kr) * FLT + ks;
            if (!sample_set[si])
              push_write(OP_WR_SAMPLE, 4'($urandom), kc[3:0], y[4:0], x[4:0], 16'($urandom));
            if (!weight_set[wi])
              push_write(OP_WR_WEIGHT, oc, kc[3:0], kr[4:0], ks[4:0], 16'($urandom));
            sum += longint'(int'(sample_mem[si]) * int'(weight_mem[wi]));
          end
        end
      end
      if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
      if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
      e.val = sum[47:0];
    end
    it.op = OP_COMPUTE; it.oc = oc; it.ic = 4'($urandom); it.row = row; it.col = col;
    it.val = 16'($urandom); it.acc = acc;
    req_q.push_back(it);
    sum_q.push_back(e);
  endtask

  // Hold until every queued transaction has gone in and every sum has come back,
  // then let the engine finish any trailing work.
  task automatic wait_idle();
    while (req_q.size() != 0 || sum_q.size() != 0 || in_valid) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IN_HEIGHT:     r_height  = data[5:0];
      REG_IN_WIDTH:      r_width   = data[5:0];
      REG_IN_CHANNELS:   r_chans   = data[4:0];
      REG_FILTER_HEIGHT: r_fh      = data[3:0];
      REG_FILTER_WIDTH:  r_fw      = data[3:0];
      REG_STRIDES:       r_strides = data;
      REG_PADDINGS:      r_pads    = data;
      REG_DILATIONS:     r_dils    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(bit [7:0] h, bit [7:0] w, bit [7:0] c, bit [7:0] fh, bit [7:0] fw,
                          bit [7:0] st, bit [7:0] pd, bit [7:0] dl);
    wait_idle();
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_CHANNELS, c);
    write_reg(REG_FILTER_HEIGHT, fh);
    write_reg(REG_FILTER_WIDTH, fw);
    write_reg(REG_STRIDES, st);
    write_reg(REG_PADDINGS, pd);
    write_reg(REG_DILATIONS, dl);
  endtask

  function automatic logic signed [47:0] pick_accum();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 48'sh7FFF_FFFF_FFFF;
    if (k < 10) return -48'sh8000_0000_0000;
    if (k < 40) return 48'({$urandom, $urandom});
    return 48'(signed'(20'($urandom)));
  endfunction

  // One random transaction: mostly computes inside the output grid, with writes,
  // out-of-grid coordinates, out-of-buffer writes and ignored opcodes mixed in.
  // Computes use the lowest and highest output channel only, so tap loads get reused.
  task automatic push_random();
    int k, ho, wo;
    bit [4:0] row, col;
    k = $urandom_range(99);
    grid_size(ho, wo);
    if (k < 20) begin
      push_write(OP_WR_SAMPLE, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                 16'($urandom));
    end else if (k < 32) begin
      row = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(FLT - 1));
      col = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(FLT - 1));
      push_write(OP_WR_WEIGHT, 4'($urandom), 4'($urandom), row, col, 16'($urandom));
    end else if (k < 36) begin
      push_write(OP_NONE, 4'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                 16'($urandom));
    end else begin
      if (k < 46 || ho == 0 || wo == 0) begin
        row = 5'($urandom); col = 5'($urandom);
      end else begin
        row = 5'($urandom_range(ho > 32 ? 31 : ho - 1));
        col = 5'($urandom_range(wo > 32 ? 31 : wo - 1));
      end
      push_compute(4'($urandom_range(1) * 15), row, col, pick_accum());
    end
  endtask

  task automatic random_phase(int n);
    wait_idle();
    set_regs(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)), 8'($urandom_range(1, 3)),
             8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
             {4'($urandom_range(3)), 4'($urandom_range(3))},
             {4'($urandom_range(2)), 4'($urandom_range(2))},
             {4'($urandom_range(2)), 4'($urandom_range(2))});
    repeat (n) push_random();
  endtask

  // Driver: present the head of the request queue at the falling edge; hold it
  // until the monitor sees the transaction go in.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
      if (!in_valid || sent_done) begin
        sent_done = 1'b0;
        if (req_q.size() != 0 && !hold_send && $urandom_range(99) >= snd_idle) begin
          in_valid       <= 1'b1;
          in_opcode      <= req_q[0].op;
          in_out_channel <= req_q[0].oc;
          in_in_channel  <= req_q[0].ic;
          in_row         <= req_q[0].row;
          in_col         <= req_q[0].col;
          in_value       <= req_q[0].val;
          in_accum_in    <= req_q[0].acc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: retire accepted requests and check each result against the oldest sum.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req_q.delete(0);
        sent_done = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (sum_q.size() == 0) begin
          $error("unexpected result transaction ch=%0d row=%0d col=%0d",
                 out_res_channel, out_res_row, out_res_col);
          failed = 1'b1;
        end else begin
          if (out_res_channel !== sum_q[0].ch) begin
            $error("res_channel expected %0d actual %0d", sum_q[0].ch, out_res_channel);
            failed = 1'b1;
          end
          if (out_res_row !== sum_q[0].row) begin
            $error("res_row expected %0d actual %0d", sum_q[0].row, out_res_row);
            failed = 1'b1;
          end
          if (out_res_col !== sum_q[0].col) begin
            $error("res_col expected %0d actual %0d", sum_q[0].col, out_res_col);
            failed = 1'b1;
          end
          if (out_result_value !== sum_q[0].val) begin
            $error("result_value expected %0d actual %0d", sum_q[0].val, out_result_value);
            failed = 1'b1;
          end
          if (out_status !== sum_q[0].status) begin
            $error("status expected %0d actual %0d", sum_q[0].status, out_status);
            failed = 1'b1;
          end
          sum_q.delete(0);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = '0; in_out_channel = '0; in_in_channel = '0;
    in_row = '0; in_col = '0; in_value = '0; in_accum_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    r_height = 32; r_width = 32; r_chans = 1; r_fh = 3; r_fw = 3;
    r_strides = 8'h11; r_pads = 8'h00; r_dils = 8'h11;
    failed = 1'b0; hold_send = 1'b0; sent_done = 1'b0;
    snd_idle = 11; rcv_idle = 77;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: full-scale negative taps drive the sum past the
    // top, then the grid corners, out-of-grid coordinates, top channel and noise.
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        push_write(OP_WR_SAMPLE, 4'd0, 4'd0, 5'(i), 5'(j), -16'sd32768);
        push_write(OP_WR_WEIGHT, 4'd0, 4'd0, 5'(i), 5'(j), -16'sd32768);
      end
    push_compute(4'd0, 5'd0, 5'd0, 48'sh7FFF_FFFF_FFFF);
    push_compute(4'd0, 5'd0, 5'd0, -48'sh8000_0000_0000);
    push_write(OP_WR_WEIGHT, 4'd15, 4'd15, 5'd31, 5'd31, 16'sd32767);
    push_write(OP_NONE, 4'd15, 4'd15, 5'd31, 5'd31, 16'sd32767);
    push_compute(4'd15, 5'd29, 5'd29, 48'sd0);
    push_compute(4'd3, 5'd30, 5'd0, 48'sd5);
    push_compute(4'd3, 5'd31, 5'd31, -48'sd1);

    // Register extremes: sizes that saturate, zero stride and dilation nibbles.
    set_regs(8'h00, 8'h3F, 8'h00, 8'h00, 8'h0F, 8'h00, 8'hFF, 8'h00);
    repeat (20) push_random();
    // Largest stride, padding and dilation: the grid is empty, all out of range.
    set_regs(8'h3F, 8'h3F, 8'h1F, 8'h0F, 8'h0F, 8'hFF, 8'hFF, 8'hFF);
    repeat (8) push_compute(4'($urandom), 5'($urandom), 5'($urandom), pick_accum());
    random_phase(40);
    random_phase(40);

    snd_idle = 77; rcv_idle = 11;
    // Full 8x8 filter over an 8x8 image: the single output element walks every
    // filter tap, and one output channel keeps the tap loads to one pass.
    set_regs(8'h08, 8'h08, 8'h01, 8'h08, 8'h08, 8'h11, 8'h00, 8'h11);
    repeat (3) push_compute(4'd7, 5'd0, 5'd0, pick_accum());
    push_compute(4'd7, 5'd1, 5'd0, pick_accum());
    random_phase(40);
    random_phase(40);

    snd_idle = 0; rcv_idle = 0;
    random_phase(40);
    random_phase(40);

    wait_idle();
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dc2d_pkg.sv
hw/rtl/dc2d_ram.sv
hw/rtl/dc2d_mac.sv
hw/rtl/direct_conv2d_engine.sv
hw/rtl/dc2d_checker.sv
tb/direct_conv2d_engine_tb.sv
